[design/scm_pkg.sv]
package scm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS   = DATA_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 4'd0,
        OP_HALT   = 4'd1,
        OP_NEGATE = 4'd2,
        OP_DUP    = 4'd3,
        OP_ADD    = 4'd4,
        OP_SUB    = 4'd5,
        OP_MUL    = 4'd6,
        OP_DIV    = 4'd7,
        OP_PUSH   = 4'd8,
        OP_POP    = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_HALTED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_FULL    = 3'd4,
        ST_STOPPED = 3'd5,
        ST_ILLEGAL = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,
        CELL_SHIFT_UP
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t top_cmd;
        cell_cmd_t rest_cmd;
        word_t     top_data;
    } stack_ctl_t;

endpackage

[design/scm_op_if.sv]
interface scm_op_if;

    logic                             valid;
    logic                             ready;
    logic [scm_pkg::OP_W-1:0]         operation;
    logic signed [scm_pkg::DATA_W-1:0] push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink (input valid, input operation, input push_value, output ready);

endinterface

[design/scm_res_if.sv]
interface scm_res_if;

    logic                              valid;
    logic                              ready;
    logic [scm_pkg::STATUS_W-1:0]      status;
    logic                              out_valid;
    logic signed [scm_pkg::DATA_W-1:0] out_value;

    modport source (output valid, output status, output out_valid, output out_value,
                    input ready);
    modport sink (input valid, input status, input out_valid, input out_value,
                  output ready);

endinterface

[design/stack_calculator_machine_core.sv]
// Channel   Modport  Payload                          Transfer
// op_in     sink     operation, push_value            valid && ready
// res_out   source   status, out_valid, out_value     valid && ready
//
// Every instruction except divide completes at its transfer edge, where its
// result is registered. Divide runs on the one-bit-per-cycle restoring
// divider (start, 32 steps, then write-back of the quotient).
// Reset clears the item count, the stopped flag and the result register; the
// stack cells are not cleared. op_in is held off during a divide and while a
// result waits and res_out is not ready.
module stack_calculator_machine_core (
    input  logic      clk,
    input  logic      rst_n,
    scm_op_if.sink    op_in,
    scm_res_if.source res_out
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    scm_pkg::count_t     cnt_reg;
    scm_pkg::count_t     cnt_next;
    logic                stopped_reg;
    logic                stopped_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    scm_pkg::status_t    res_status_reg;
    scm_pkg::status_t    res_status_next;
    logic                res_flag_reg;
    logic                res_flag_next;
    scm_pkg::word_t      res_value_reg;
    scm_pkg::word_t      res_value_next;

    logic                accept;
    logic                load_res;
    logic                is_empty;
    logic                is_full;
    logic                below_two;
    logic                div_start;
    logic                div_done;
    scm_pkg::word_t      quotient;
    scm_pkg::word_t      top;
    scm_pkg::word_t      next;
    scm_pkg::word_t      arith;
    scm_pkg::stack_ctl_t ctl;

    assign op_in.ready = (state_reg == S_IDLE) && (!res_valid_reg || res_out.ready);
    assign accept      = op_in.valid && op_in.ready;
    assign is_empty    = (cnt_reg == '0);
    assign is_full     = (cnt_reg == scm_pkg::count_t'(scm_pkg::STACK_DEPTH));
    assign below_two   = (cnt_reg < scm_pkg::count_t'(2));

    always_comb
    begin
        case (op_in.operation)
            scm_pkg::OP_SUB: arith = top - next;
            scm_pkg::OP_MUL: arith = top * next;
            default:         arith = top + next;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        stopped_next    = stopped_reg;
        res_valid_next  = res_valid_reg && !res_out.ready;
        res_status_next = res_status_reg;
        res_flag_next   = res_flag_reg;
        res_value_next  = res_value_reg;
        load_res        = 1'b0;
        div_start       = 1'b0;
        ctl.top_cmd     = scm_pkg::CELL_HOLD;
        ctl.rest_cmd    = scm_pkg::CELL_HOLD;
        ctl.top_data    = op_in.push_value;
        res_status_next = scm_pkg::ST_OK;
        res_flag_next   = 1'b0;
        res_value_next  = '0;
        if (accept)
        begin
            load_res = 1'b1;
            if (stopped_reg)
            begin
                res_status_next = scm_pkg::ST_STOPPED;
            end
            else
            begin
                unique case (op_in.operation) inside
                    scm_pkg::OP_CLEAR:
                    begin
                        cnt_next = '0;
                    end
                    scm_pkg::OP_HALT:
                    begin
                        res_status_next = scm_pkg::ST_HALTED;
                        stopped_next    = 1'b1;
                    end
                    scm_pkg::OP_NEGATE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = scm_pkg::ST_EMPTY;
                            stopped_next    = 1'b1;
                        end
                        else
                        begin
                            ctl.top_cmd  = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.top_data = scm_pkg::word_t'(0) - top;
                        end
                    end
                    scm_pkg::OP_DUP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = scm_pkg::ST_EMPTY;
                            stopped_next    = 1'b1;
                        end
                        else if (is_full)
                        begin
                            res_status_next = scm_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.top_cmd  = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.rest_cmd = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.top_data = top;
                            cnt_next     = cnt_reg + scm_pkg::count_t'(1);
                        end
                    end
                    scm_pkg::OP_POP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = scm_pkg::ST_EMPTY;
                            stopped_next    = 1'b1;
                        end
                        else
                        begin
                            ctl.top_cmd    = scm_pkg::CELL_SHIFT_UP;
                            ctl.rest_cmd   = scm_pkg::CELL_SHIFT_UP;
                            cnt_next       = cnt_reg - scm_pkg::count_t'(1);
                            res_flag_next  = 1'b1;
                            res_value_next = top;
                        end
                    end
                    scm_pkg::OP_ADD, scm_pkg::OP_SUB, scm_pkg::OP_MUL:
                    begin
                        if (below_two)
                        begin
                            res_status_next = scm_pkg::ST_EMPTY;
                            stopped_next    = 1'b1;
                        end
                        else
                        begin
                            ctl.top_cmd  = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.rest_cmd = scm_pkg::CELL_SHIFT_UP;
                            ctl.top_data = arith;
                            cnt_next     = cnt_reg - scm_pkg::count_t'(1);
                        end
                    end
                    scm_pkg::OP_DIV:
                    begin
                        if (below_two)
                        begin
                            res_status_next = scm_pkg::ST_EMPTY;
                            stopped_next    = 1'b1;
                        end
                        else if (next == '0)
                        begin
                            res_status_next = scm_pkg::ST_DIVZERO;
                            stopped_next    = 1'b1;
                        end
                        else
                        begin
                            load_res   = 1'b0;
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    scm_pkg::OP_PUSH:
                    begin
                        if (is_full)
                        begin
                            res_status_next = scm_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctl.top_cmd  = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.rest_cmd = scm_pkg::CELL_SHIFT_DOWN;
                            ctl.top_data = op_in.push_value;
                            cnt_next     = cnt_reg + scm_pkg::count_t'(1);
                        end
                    end
                    default:
                    begin
                        res_status_next = scm_pkg::ST_ILLEGAL;
                    end
                endcase
            end
        end
        else if (state_reg == S_DIV && div_done)
        begin
            load_res     = 1'b1;
            ctl.top_cmd  = scm_pkg::CELL_SHIFT_DOWN;
            ctl.rest_cmd = scm_pkg::CELL_SHIFT_UP;
            ctl.top_data = quotient;
            cnt_next     = cnt_reg - scm_pkg::count_t'(1);
            state_next   = S_IDLE;
        end
        if (load_res)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_status_next = res_status_reg;
            res_flag_next   = res_flag_reg;
            res_value_next  = res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            stopped_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= scm_pkg::ST_OK;
            res_flag_reg   <= 1'b0;
            res_value_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            stopped_reg    <= stopped_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_flag_reg   <= res_flag_next;
            res_value_reg  <= res_value_next;
        end
    end

    scm_stack u_stack (
        .clk  (clk),
        .ctl  (ctl),
        .top  (top),
        .next (next)
    );

    scm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (top),
        .divisor  (next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign res_out.valid     = res_valid_reg;
    assign res_out.status    = res_status_reg;
    assign res_out.out_valid = res_flag_reg;
    assign res_out.out_value = res_value_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= scm_pkg::count_t'(scm_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(stopped_reg))
        else $error("stopped flag cleared without reset");

    a_stopped_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stopped_reg) |=> (res_valid_reg && res_status_reg == scm_pkg::ST_STOPPED))
        else $error("stopped machine did not report stopped");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside a divide");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !stopped_reg && op_in.operation == scm_pkg::OP_PUSH && !is_full)
        |=> (cnt_reg == $past(cnt_reg) + scm_pkg::count_t'(1)))
        else $error("push did not grow the stack");
`endif

endmodule

[design/scm_stack_cell.sv]
module scm_stack_cell (
    input  logic               clk,
    input  scm_pkg::cell_cmd_t cmd,
    input  scm_pkg::word_t     above,
    input  scm_pkg::word_t     below,
    output scm_pkg::word_t     data
);

    scm_pkg::word_t data_reg;
    scm_pkg::word_t data_next;

    always_comb
    begin
        case (cmd)
            scm_pkg::CELL_SHIFT_DOWN: data_next = above;
            scm_pkg::CELL_SHIFT_UP:   data_next = below;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[design/scm_stack.sv]
module scm_stack (
    input  logic                clk,
    input  scm_pkg::stack_ctl_t ctl,
    output scm_pkg::word_t      top,
    output scm_pkg::word_t      next
);

    scm_pkg::word_t cell_q [scm_pkg::STACK_DEPTH];

    for (genvar i = 0; i < scm_pkg::STACK_DEPTH; i++) begin : g_cell
        scm_pkg::cell_cmd_t cell_cmd;
        scm_pkg::word_t     cell_above;
        scm_pkg::word_t     cell_below;

        if (i == 0) begin : g_first
            assign cell_cmd   = ctl.top_cmd;
            assign cell_above = ctl.top_data;
        end else begin : g_inner
            assign cell_cmd   = ctl.rest_cmd;
            assign cell_above = cell_q[i-1];
        end

        if (i == scm_pkg::STACK_DEPTH - 1) begin : g_last
            assign cell_below = '0;
        end else begin : g_mid
            assign cell_below = cell_q[i+1];
        end

        scm_stack_cell u_cell (
            .clk   (clk),
            .cmd   (cell_cmd),
            .above (cell_above),
            .below (cell_below),
            .data  (cell_q[i])
        );
    end

    assign top  = cell_q[0];
    assign next = cell_q[1];

endmodule

[design/scm_divider.sv]
module scm_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  scm_pkg::word_t dividend,
    input  scm_pkg::word_t divisor,
    output logic           done,
    output scm_pkg::word_t quotient
);

    localparam int W = scm_pkg::DATA_W;

    logic                        busy_reg;
    logic                        busy_next;
    logic                        done_reg;
    logic                        done_next;
    logic [scm_pkg::STEP_W-1:0]  step_reg;
    logic [scm_pkg::STEP_W-1:0]  step_next;
    scm_pkg::word_t              rem_reg;
    scm_pkg::word_t              rem_next;
    scm_pkg::word_t              quo_reg;
    scm_pkg::word_t              quo_next;
    scm_pkg::word_t              den_reg;
    scm_pkg::word_t              den_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [W:0]                  shifted;
    logic [W:0]                  diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = scm_pkg::STEP_W'(scm_pkg::DIV_STEPS);
            rem_next  = '0;
            quo_next  = dividend[W-1] ? (W'(0) - dividend) : dividend;
            den_next  = divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            step_next = step_reg - scm_pkg::STEP_W'(1);
            if (step_reg == scm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule
